// File: hdl/gtb_pkg.sv
// Package for the gated timer bank: item types, event codes and mode bit positions.
// Used by gtb_chan and by the top level gated_timer_bank_target_overflow.
package gtb_pkg;

	typedef enum logic [3:0] {
		K_TICK    = 4'd0,
		K_HB_ON   = 4'd1,
		K_HB_OFF  = 4'd2,
		K_VB_ON   = 4'd3,
		K_VB_OFF  = 4'd4,
		K_WR_CNT  = 4'd5,
		K_WR_MODE = 4'd6,
		K_WR_TGT  = 4'd7,
		K_RD_CNT  = 4'd8
	} kind_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  channel;
		logic [31:0] write_value;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [5:0]  irq_pulses;
	} result_t;

	// Per-channel state record.
	typedef struct packed {
		logic [31:0] cnt;
		logic        fut;
		logic [31:0] tgt;
		logic [16:0] mode;
		logic [1:0]  lat;
		logic [7:0]  ph;
	} chan_t;

	localparam int NCH = 6;
	localparam logic [16:0] MODE_WR_MASK = 17'h063FF;
	localparam logic [16:0] MODE_FL_MASK = 17'h01C00;
	localparam logic [16:0] MODE_RESET   = 17'h00400;
	localparam int B_GATE = 0;
	localparam int B_ZRET = 3;
	localparam int B_TIRQ = 4;
	localparam int B_OIRQ = 5;
	localparam int B_REP  = 6;
	localparam int B_TOG  = 7;
	localparam int B_EXT  = 8;
	localparam int B_T2P  = 9;
	localparam int B_IEN  = 10;
	localparam int B_TFL  = 11;
	localparam int B_OFL  = 12;
	localparam int B_STOP = 16;

endpackage

// File: hdl/gtb_chan.sv
// Shared channel update unit: applies one event to one channel record per cycle.
// Depends on gtb_pkg.
module gtb_chan import gtb_pkg::*; (
	input  logic [2:0]  ch,
	input  logic [3:0]  kind,
	input  logic [31:0] wval,
	input  logic        hb,
	input  logic        vb,
	input  chan_t       cur,
	output chan_t       nxt,
	output logic        pulse,
	output logic [31:0] rd
);

	function automatic logic [8:0] rate_f(input logic [2:0] c, input logic [16:0] m);
		logic [8:0] r;
		begin
			r = 9'd1;
			case (c)
				3'd0: r = m[B_EXT] ? 9'd3 : 9'd1;
				3'd1, 3'd3: r = m[B_EXT] ? 9'd0 : 9'd1;
				3'd2: r = m[B_T2P] ? 9'd8 : 9'd1;
				default: begin
					case (m[14:13])
						2'd1: r = 9'd8;
						2'd2: r = 9'd16;
						2'd3: r = 9'd256;
						default: r = 9'd1;
					endcase
				end
			endcase
			return r;
		end
	endfunction

	function automatic logic can_f(input logic [2:0] c, input logic [16:0] m,
			input logic h, input logic v);
		logic bl;
		logic [1:0] g;
		begin
			g = m[2:1];
			bl = (c == 3'd0) ? h : v;
			if (m[B_STOP]) return 1'b0;
			if (!m[B_GATE]) return 1'b1;
			if (c == 3'd2 || c == 3'd4 || c == 3'd5) return g[0];
			if ((g == 2'd0 && bl) || (g == 2'd2 && !bl)) return 1'b0;
			return 1'b1;
		end
	endfunction

	// Settle step, then the per-kind action, then increment with its tests.
	always_comb begin
		chan_t s;
		logic wide;
		logic [31:0] maxv;
		logic do_bump;
		logic [32:0] c1;
		logic upd, tog, ovf, tg;
		logic [8:0] r;
		logic [15:0] w16;
		logic [31:0] v;
		s = cur;
		pulse = 1'b0;
		rd = '0;
		do_bump = 1'b0;
		c1 = '0;
		upd = 1'b0;
		tog = 1'b0;
		ovf = 1'b0;
		tg = 1'b0;
		wide = (ch >= 3'd3);
		maxv = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
		w16 = wval[15:0];
		v = wide ? wval : {16'd0, w16};
		r = rate_f(ch, s.mode);
		// Settle, used by most events before they act.
		unique case (kind)
			K_TICK, K_WR_CNT, K_WR_TGT, K_RD_CNT: begin
				if (kind == K_WR_TGT) begin
					s.tgt = v;
					s.fut = 1'b0;
				end
				if (s.lat[0] && !s.lat[1]) s.mode[B_IEN] = 1'b1;
				if (!(can_f(ch, s.mode, hb, vb) && r != 9'd0)) begin
					if (s.mode[B_GATE] && s.mode[2:1] == 2'd2) s.cnt = '0;
					s.ph = '0;
				end
				if (kind == K_TICK) begin
					if (r != 9'd0 && can_f(ch, s.mode, hb, vb)) begin
						if ({1'b0, s.ph} + 9'd1 >= r) begin
							s.ph = '0;
							do_bump = 1'b1;
						end else begin
							s.ph = s.ph + 8'd1;
						end
					end
				end else if (kind == K_WR_CNT) begin
					s.cnt = v;
					s.tgt = s.tgt & maxv;
					s.fut = 1'b0;
					if (s.cnt > s.tgt) s.fut = 1'b1;
				end else if (kind == K_WR_TGT) begin
					if (s.tgt <= s.cnt) s.fut = 1'b1;
				end else begin
					rd = s.cnt & maxv;
				end
			end
			K_HB_ON, K_VB_ON: begin
				if ((ch == 3'd1 || ch == 3'd3) && kind == K_HB_ON) begin
					do_bump = (r == 9'd0) && can_f(ch, s.mode, hb, vb);
				end else if (s.mode[B_GATE] && (s.mode[2:1] == 2'd0 || s.mode[2:1] == 2'd2)) begin
					if (s.lat[0] && !s.lat[1]) s.mode[B_IEN] = 1'b1;
					if (!(can_f(ch, s.mode, hb, vb) && r != 9'd0)) begin
						if (s.mode[2:1] == 2'd2) s.cnt = '0;
						s.ph = '0;
					end
					if (s.mode[2:1] == 2'd0) begin
						if (!wide) s.cnt = s.cnt & 32'h0000_FFFF;
						s.ph = '0;
					end else begin
						s.mode[B_STOP] = 1'b0;
						s.cnt = '0;
						s.fut = 1'b0;
					end
				end
			end
			K_HB_OFF, K_VB_OFF: begin
				if (s.mode[B_GATE]) begin
					case (s.mode[2:1])
						2'd0: s.ph = '0;
						2'd3: begin
							if (s.mode[B_STOP]) begin
								s.ph = '0;
								s.mode[B_STOP] = 1'b0;
							end
						end
						default: begin
							if (s.lat[0] && !s.lat[1]) s.mode[B_IEN] = 1'b1;
							if (!(can_f(ch, s.mode, hb, vb) && r != 9'd0)) s.ph = '0;
							s.cnt = '0;
							s.fut = 1'b0;
						end
					endcase
				end
			end
			K_WR_MODE: begin
				s.mode = (wval[16:0] & MODE_WR_MASK) | (cur.mode & MODE_FL_MASK);
				if (!((cur.mode[B_TFL] || cur.mode[B_OFL]) &&
						(cur.mode[B_TIRQ] || cur.mode[B_OIRQ]))) begin
					s.mode[B_TFL] = 1'b0;
					s.mode[B_OFL] = 1'b0;
					s.mode[B_IEN] = 1'b1;
					s.lat = {s.mode[B_TOG], s.mode[B_REP]};
				end
				if ((ch == 3'd0 || ch == 3'd1 || ch == 3'd3) && s.mode[B_GATE] &&
						s.mode[2]) s.mode[B_STOP] = 1'b1;
				s.cnt = '0;
				s.ph = '0;
				s.tgt = s.tgt & maxv;
				s.fut = 1'b0;
			end
			default: ;
		endcase
		// Increment with overflow test, then target test.
		if (do_bump) begin
			c1 = {1'b0, s.cnt} + 33'd1;
			ovf = wide ? c1[32] : c1[16];
			if (ovf) begin
				if (s.mode[B_OIRQ]) begin
					upd = s.lat[0];
					tog = s.lat[1];
					if (s.mode[B_IEN]) begin
						if (upd || !s.mode[B_OFL]) pulse = 1'b1;
						upd = upd || tog;
					end
					if (upd) s.mode[B_IEN] = tog ? ~s.mode[B_IEN] : 1'b0;
				end
				s.mode[B_OFL] = 1'b1;
				s.cnt = '0;
				s.tgt = s.tgt & maxv;
				s.fut = 1'b0;
			end else begin
				s.cnt = c1[31:0];
			end
			tg = !s.fut && (s.cnt >= s.tgt);
			if (tg) begin
				if (s.mode[B_TIRQ]) begin
					upd = s.lat[0];
					tog = s.lat[1];
					if (s.mode[B_IEN]) begin
						if (upd || !s.mode[B_TFL]) pulse = 1'b1;
						upd = upd || tog;
					end
					if (upd) s.mode[B_IEN] = tog ? ~s.mode[B_IEN] : 1'b0;
				end
				s.mode[B_TFL] = 1'b1;
				if (s.mode[B_ZRET]) s.cnt = s.cnt - s.tgt;
				else s.fut = 1'b1;
			end
		end
		nxt = s;
	end

endmodule

// File: hdl/gated_timer_bank_target_overflow.sv
// Top level of the six-channel gated timer bank with its sequencer and state.
// Depends on gtb_pkg and gtb_chan.
// A tick item sweeps all six channels through one shared update unit, one
// channel per cycle, and then gives its result beat. A blank edge or register
// access touches one to three channels (hblank start visits channels 1, 3
// and 0); an unknown kind or a register access to channel 6 or 7 goes
// straight to its result beat.
// busy is high from the accepted start until the result beat, marked by done,
// has been shown for its single cycle; results cannot be held off.
module gated_timer_bank_target_overflow import gtb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

	state_t      state_q;
	item_t       item_q;
	logic [2:0]  ch_q;
	logic [2:0]  last_q;
	chan_t       regs_q [NCH];
	logic        hb_q, vb_q;
	logic [31:0] rd_q;
	logic [5:0]  irq_q;
	chan_t       nxt;
	logic        pulse;
	logic [31:0] rd;
	logic        hb_n, vb_n;

	gtb_chan u_chan (
		.ch(ch_q), .kind(item_q.kind), .wval(item_q.write_value),
		.hb(hb_q), .vb(vb_q), .cur(regs_q[ch_q]), .nxt(nxt), .pulse(pulse), .rd(rd)
	);

	// Blank flags change after the last channel of a blank item.
	always_comb begin
		hb_n = hb_q;
		vb_n = vb_q;
		case (item_q.kind)
			K_HB_ON:  hb_n = 1'b1;
			K_HB_OFF: hb_n = 1'b0;
			K_VB_ON:  vb_n = 1'b1;
			K_VB_OFF: vb_n = 1'b0;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);
	assign result.read_data = rd_q;
	assign result.irq_pulses = irq_q;

	// Sequencer: picks the channel list for the item and walks it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			rd_q <= '0;
			irq_q <= '0;
			hb_q <= 1'b0;
			vb_q <= 1'b0;
			ch_q <= '0;
			last_q <= '0;
			for (int i = 0; i < NCH; i++) begin
				regs_q[i] <= '{cnt: 32'd0, fut: 1'b1, tgt: 32'd0, mode: MODE_RESET,
					lat: 2'd0, ph: 8'd0};
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q <= item;
						rd_q <= '0;
						irq_q <= '0;
						state_q <= S_RUN;
						case (item.kind)
							K_TICK: begin ch_q <= 3'd0; last_q <= 3'd5; end
							K_HB_ON: begin ch_q <= 3'd1; last_q <= 3'd0; end
							K_HB_OFF: begin ch_q <= 3'd0; last_q <= 3'd0; end
							K_VB_ON, K_VB_OFF: begin ch_q <= 3'd1; last_q <= 3'd3; end
							K_WR_CNT, K_WR_MODE, K_WR_TGT, K_RD_CNT: begin
								ch_q <= item.channel;
								last_q <= item.channel;
								if (item.channel > 3'd5) state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_RUN: begin
					regs_q[ch_q] <= nxt;
					irq_q[ch_q] <= irq_q[ch_q] | pulse;
					if (item_q.kind == K_RD_CNT) rd_q <= rd;
					if (ch_q == last_q) begin
						hb_q <= hb_n;
						vb_q <= vb_n;
						state_q <= S_OUT;
					end else if (item_q.kind == K_HB_ON) begin
						ch_q <= (ch_q == 3'd1) ? 3'd3 : 3'd0;
					end else if (item_q.kind == K_VB_ON || item_q.kind == K_VB_OFF) begin
						ch_q <= 3'd3;
					end else begin
						ch_q <= ch_q + 3'd1;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/gtb_check.sv
// Port-level checker for the timer bank, bound to the top level.
// Depends on gtb_pkg for the item and result types.
module gtb_check import gtb_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    done,
	input result_t result
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind != K_RD_CNT) |=> ##1 !(done && result.read_data != 0))
		else $error("read data on a non-read item");

endmodule

bind gated_timer_bank_target_overflow gtb_check u_check (.*);

// File: sim/gated_timer_bank_target_overflow_tb.sv
// Self-checking testbench for the six-channel gated timer bank.
// Depends on gtb_pkg and the top level gated_timer_bank_target_overflow.
// A built-in timer model predicts every result beat and a monitor compares them.
module gated_timer_bank_target_overflow_tb;
	import gtb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam logic [16:0] M_GATE = 17'h00001;
	localparam logic [16:0] M_ZRET = 17'h00008;
	localparam logic [16:0] M_TIRQ = 17'h00010;
	localparam logic [16:0] M_OIRQ = 17'h00020;
	localparam logic [16:0] M_EXTS = 17'h00100;
	localparam logic [16:0] M_T2PR = 17'h00200;
	localparam logic [16:0] M_IENB = 17'h00400;
	localparam logic [16:0] M_TFLG = 17'h00800;
	localparam logic [16:0] M_OFLG = 17'h01000;
	localparam logic [16:0] M_STPD = 17'h10000;

	logic clk;
	logic arst_n;
	logic start;
	item_t item;
	logic busy;
	logic done;
	result_t result;

	gated_timer_bank_target_overflow uut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	// Timer model state.
	logic [31:0] tm_count [NCH];
	logic [32:0] tm_target [NCH];
	logic [16:0] tm_mode [NCH];
	logic [1:0]  tm_latch [NCH];
	logic [7:0]  tm_phase [NCH];
	logic        tm_hblank;
	logic        tm_vblank;
	logic [5:0]  tm_irq;

	item_t   pending_items [$];
	result_t expected_beats [$];
	int      fail_count;
	int      beats_checked;
	int      irq_beats;
	int      cycle_count;
	int      send_idle_pct;

	function automatic logic [31:0] chan_max(int ch);
		return (ch < 3) ? 32'h0000FFFF : 32'hFFFFFFFF;
	endfunction

	// Divide of a channel; zero means the channel counts hblank events.
	function automatic int chan_rate(int ch);
		logic [16:0] m;
		m = tm_mode[ch];
		case (ch)
			0: return (m & M_EXTS) ? 3 : 1;
			1, 3: return (m & M_EXTS) ? 0 : 1;
			2: return (m & M_T2PR) ? 8 : 1;
			default: begin
				case (m[14:13])
					2'd1: return 8;
					2'd2: return 16;
					2'd3: return 256;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	function automatic bit chan_runs(int ch);
		logic [16:0] m;
		logic [1:0] g;
		bit blank;
		m = tm_mode[ch];
		g = m[2:1];
		if (m & M_STPD) return 0;
		if (!(m & M_GATE)) return 1;
		if (ch == 2 || ch == 4 || ch == 5) return g[0];
		blank = (ch == 0) ? tm_hblank : tm_vblank;
		if ((g == 2'd0 && blank) || (g == 2'd2 && !blank)) return 0;
		return 1;
	endfunction

	// Brings a channel up to date outside of counting.
	function automatic void chan_settle(int ch);
		if (tm_latch[ch][0] && !tm_latch[ch][1]) tm_mode[ch] |= M_IENB;
		if (!(chan_runs(ch) && chan_rate(ch) != 0)) begin
			if ((tm_mode[ch] & M_GATE) && tm_mode[ch][2:1] == 2'd2) tm_count[ch] = 0;
			tm_phase[ch] = 0;
		end
	endfunction

	function automatic void chan_raise(int ch, bit ovf);
		bit upd;
		bit tog;
		bit already;
		upd = tm_latch[ch][0];
		tog = tm_latch[ch][1];
		if (tm_mode[ch] & M_IENB) begin
			already = (tm_mode[ch] & (ovf ? M_OFLG : M_TFLG)) != 0;
			if (upd || !already) tm_irq[ch] = 1'b1;
			upd = upd || tog;
		end
		if (upd) begin
			if (tog) tm_mode[ch] ^= M_IENB;
			else tm_mode[ch] &= ~M_IENB;
		end
	endfunction

	// One increment followed by the overflow and target tests.
	function automatic void chan_increment(int ch);
		logic [32:0] c;
		logic [32:0] mx;
		mx = {1'b0, chan_max(ch)};
		c = {1'b0, tm_count[ch]} + 33'd1;
		if (c > mx) begin
			if (tm_mode[ch] & M_OIRQ) chan_raise(ch, 1);
			tm_mode[ch] |= M_OFLG;
			c = c - (mx + 33'd1);
			tm_target[ch] &= mx;
		end
		tm_count[ch] = c[31:0];
		if (tm_target[ch][32]) return;
		if ({1'b0, tm_count[ch]} < tm_target[ch]) return;
		if (tm_mode[ch] & M_TIRQ) chan_raise(ch, 0);
		tm_mode[ch] |= M_TFLG;
		if (tm_mode[ch] & M_ZRET) tm_count[ch] -= tm_target[ch][31:0];
		else tm_target[ch][32] = 1'b1;
	endfunction

	function automatic void chan_tick(int ch);
		int r;
		r = chan_rate(ch);
		chan_settle(ch);
		if (r == 0 || !chan_runs(ch)) return;
		if (int'(tm_phase[ch]) + 1 >= r) begin
			tm_phase[ch] = 0;
			chan_increment(ch);
		end else begin
			tm_phase[ch]++;
		end
	endfunction

	function automatic void gate_open(int ch);
		if (!(tm_mode[ch] & M_GATE)) return;
		case (tm_mode[ch][2:1])
			2'd0: begin
				chan_settle(ch);
				if (ch < 3) tm_count[ch] &= 32'hFFFF;
				tm_phase[ch] = 0;
			end
			2'd2: begin
				chan_settle(ch);
				tm_mode[ch] &= ~M_STPD;
				tm_count[ch] = 0;
				tm_target[ch][32] = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic void gate_close(int ch);
		if (!(tm_mode[ch] & M_GATE)) return;
		case (tm_mode[ch][2:1])
			2'd0: tm_phase[ch] = 0;
			2'd1, 2'd2: begin
				chan_settle(ch);
				tm_count[ch] = 0;
				tm_target[ch][32] = 1'b0;
			end
			default: begin
				if (tm_mode[ch] & M_STPD) begin
					tm_phase[ch] = 0;
					tm_mode[ch] &= ~M_STPD;
				end
			end
		endcase
	endfunction

	function automatic void hblank_event(int ch);
		if (chan_rate(ch) == 0 && chan_runs(ch)) chan_increment(ch);
	endfunction

	function automatic void mode_write(int ch, logic [31:0] v);
		logic [16:0] old;
		old = tm_mode[ch];
		tm_mode[ch] = (v[16:0] & MODE_WR_MASK) | (old & MODE_FL_MASK);
		if (!((old & (M_TFLG | M_OFLG)) != 0 && (old & (M_TIRQ | M_OIRQ)) != 0)) begin
			tm_mode[ch] &= ~(M_TFLG | M_OFLG);
			tm_mode[ch] |= M_IENB;
			tm_latch[ch] = {tm_mode[ch][B_TOG], tm_mode[ch][B_REP]};
		end
		if ((ch == 0 || ch == 1 || ch == 3) && (tm_mode[ch] & M_GATE) &&
				tm_mode[ch][2:1] >= 2'd2)
			tm_mode[ch] |= M_STPD;
		tm_count[ch] = 0;
		tm_phase[ch] = 0;
		tm_target[ch] &= {1'b0, chan_max(ch)};
	endfunction

	task automatic model_reset();
		for (int i = 0; i < NCH; i++) begin
			tm_count[i] = 0;
			tm_target[i] = 33'h100000000;
			tm_mode[i] = MODE_RESET;
			tm_latch[i] = 0;
			tm_phase[i] = 0;
		end
		tm_hblank = 0;
		tm_vblank = 0;
	endtask

	// Works out the result beat of one accepted item.
	function automatic result_t timer_step(item_t it);
		result_t r;
		int ch;
		logic [31:0] v;
		logic [32:0] mx;
		r = '0;
		tm_irq = 0;
		ch = it.channel;
		v = it.write_value;
		case (it.kind)
			K_TICK: for (int i = 0; i < NCH; i++) chan_tick(i);
			K_HB_ON: begin
				hblank_event(1);
				hblank_event(3);
				gate_open(0);
				tm_hblank = 1;
			end
			K_HB_OFF: begin
				gate_close(0);
				tm_hblank = 0;
			end
			K_VB_ON: begin
				gate_open(1);
				gate_open(3);
				tm_vblank = 1;
			end
			K_VB_OFF: begin
				gate_close(1);
				gate_close(3);
				tm_vblank = 0;
			end
			K_WR_CNT, K_WR_MODE, K_WR_TGT, K_RD_CNT: begin
				if (ch < NCH) begin
					mx = {1'b0, chan_max(ch)};
					if (ch < 3) v &= 32'hFFFF;
					if (it.kind == K_WR_CNT) begin
						chan_settle(ch);
						tm_count[ch] = v;
						tm_target[ch] &= mx;
						if ({1'b0, tm_count[ch]} > tm_target[ch]) tm_target[ch][32] = 1'b1;
					end else if (it.kind == K_WR_MODE) begin
						mode_write(ch, v);
					end else if (it.kind == K_WR_TGT) begin
						tm_target[ch] = {1'b0, v};
						chan_settle(ch);
						if (tm_target[ch] <= {1'b0, tm_count[ch]}) tm_target[ch][32] = 1'b1;
					end else begin
						chan_settle(ch);
						r.read_data = (ch < 3) ? (tm_count[ch] & 32'hFFFF) : tm_count[ch];
					end
				end
			end
			default: ;
		endcase
		r.irq_pulses = tm_irq;
		return r;
	endfunction

	function automatic item_t make_item(logic [3:0] k, int ch, logic [31:0] v);
		item_t it;
		it.kind = k;
		it.channel = ch[2:0];
		it.write_value = v;
		return it;
	endfunction

	// Mostly ticks, with enough register traffic and blank edges to reach
	// overflow, target and every gate mode.
	function automatic item_t random_item();
		int sel;
		int ch;
		logic [31:0] v;
		sel = $urandom_range(99);
		ch = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(5);
		v = $urandom();
		if (sel < 50) return make_item(K_TICK, ch, v);
		if (sel < 62) return make_item(4'($urandom_range(1, 4)), ch, v);
		if (sel < 70) begin
			// Half the time, park the count just below a wrap.
			if ($urandom_range(1)) v = chan_max(ch) - $urandom_range(6);
			return make_item(K_WR_CNT, ch, v);
		end
		if (sel < 78) begin
			v[16:15] = 0;
			return make_item(K_WR_MODE, ch, v);
		end
		if (sel < 86) begin
			if ($urandom_range(2) != 0) v = $urandom_range(12);
			return make_item(K_WR_TGT, ch, v);
		end
		if (sel < 97) return make_item(K_RD_CNT, ch, v);
		return make_item(4'($urandom_range(9, 15)), ch, v);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Driver: presents the next pending item and holds it until the bank accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy) begin
				expected_beats.push_back(timer_step(item));
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
				end else begin
					start <= 1'b0;
				end
			end else if (!start && pending_items.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				item <= pending_items.pop_front();
			end
		end
	end

	// Monitor: compares every result beat with the oldest expected beat.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat: read_data %h irq_pulses %h",
					result.read_data, result.irq_pulses);
				fail_count++;
			end else begin
				result_t e;
				e = expected_beats.pop_front();
				if (result.read_data !== e.read_data) begin
					$error("read_data expected %h actual %h", e.read_data, result.read_data);
					fail_count++;
				end
				if (result.irq_pulses !== e.irq_pulses) begin
					$error("irq_pulses expected %h actual %h", e.irq_pulses, result.irq_pulses);
					fail_count++;
				end
				beats_checked++;
				if (e.irq_pulses != 0) irq_beats++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("gated_timer_bank_target_overflow_tb NOT OK");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || start || expected_beats.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int pct [4];
		pct = '{0, 85, 0, 33};
		fail_count = 0;
		beats_checked = 0;
		irq_beats = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		model_reset();
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: extremes, every kind, wrap and target, bad channel.
		pending_items.push_back(make_item(K_RD_CNT, 0, 32'hFFFFFFFF));
		pending_items.push_back(make_item(K_WR_MODE, 3, 32'h00000038));
		pending_items.push_back(make_item(K_WR_CNT, 3, 32'hFFFFFFFE));
		pending_items.push_back(make_item(K_WR_TGT, 0, 32'h00000002));
		pending_items.push_back(make_item(K_WR_MODE, 0, 32'h000000F8));
		pending_items.push_back(make_item(K_WR_TGT, 0, 32'hFFFF0002));
		repeat (5) pending_items.push_back(make_item(K_TICK, 7, 32'h0));
		pending_items.push_back(make_item(K_WR_MODE, 1, 32'h00000105));
		pending_items.push_back(make_item(K_VB_ON, 0, 32'h0));
		pending_items.push_back(make_item(K_HB_ON, 0, 32'h0));
		pending_items.push_back(make_item(K_HB_OFF, 0, 32'h0));
		pending_items.push_back(make_item(K_VB_OFF, 0, 32'h0));
		pending_items.push_back(make_item(K_WR_MODE, 5, 32'h00006000));
		pending_items.push_back(make_item(K_WR_CNT, 6, 32'hFFFFFFFF));
		pending_items.push_back(make_item(K_RD_CNT, 7, 32'h0));
		pending_items.push_back(make_item(4'hF, 5, 32'hFFFFFFFF));
		pending_items.push_back(make_item(K_WR_MODE, 2, 32'h0000FFFF));
		pending_items.push_back(make_item(K_TICK, 0, 32'h0));
		for (int i = 0; i < NCH; i++) pending_items.push_back(make_item(K_RD_CNT, i, 32'h0));
		wait_drained();

		// Random part in several idling phases; each phase ends drained.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = pct[p];
			for (int n = 0; n < 410; n++) pending_items.push_back(random_item());
			wait_drained();
		end
		repeat (20) @(posedge clk);

		$display("checked %0d result beats, %0d of them carrying interrupt pulses",
			beats_checked, irq_beats);
		if (fail_count == 0 && expected_beats.size() == 0) begin
			$display("gated_timer_bank_target_overflow_tb OK");
		end else begin
			$display("gated_timer_bank_target_overflow_tb NOT OK");
		end
		$finish;
	end
endmodule
